// ----- hdl/ple_pkg.sv -----
package ple_pkg;

    typedef enum logic [2:0] {
        FUNC_INSERT = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_GET    = 3'd2,
        FUNC_SET    = 3'd3,
        FUNC_CLEAR  = 3'd4
    } func_t;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic write;
    } cell_ctl_t;

    localparam int FUNC_W     = 3;
    localparam int POSITION_W = 7;
    localparam int VALUE_W    = 32;
    localparam int LENGTH_W   = 7;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

endpackage

// ----- hdl/positional_list_engine.sv -----
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle; every cell shifts, writes or holds in the same cycle.
// A result waiting in the output register does not block the next item unless m_tready is low.
// Reset (aresetn low, synchronous) empties the list and drops any pending result;
// entry storage is not cleared and needs no clearing pass.
module positional_list_engine #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: func[2:0], position[9:3], value[41:10], zero fill above
    input  logic [ple_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // m_tdata: ok[0], read_value[32:1], length[39:33], is_empty[40], zero fill above
    output logic [ple_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import ple_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = ((CW > POSITION_W) ? CW : POSITION_W) + 1;

    logic                  accept;
    func_t                 func_in;
    logic [POSITION_W-1:0] pos_in;
    logic [VALUE_W-1:0]    val_in;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [IDX_W-1:0]      sel_idx;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  op_ok;
    logic                  is_get;
    cell_ctl_t             ctl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      cell_hit;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  out_valid_reg;
    logic                  ok_reg;
    logic [VALUE_W-1:0]    read_value_reg;
    logic [LENGTH_W-1:0]   length_reg;
    logic                  is_empty_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign func_in = func_t'(s_tdata[2:0]);
    assign pos_in  = s_tdata[9:3];
    assign val_in  = s_tdata[41:10];
    assign pos_ext = CMP_W'(pos_in);
    assign cnt_ext = CMP_W'(count_reg);
    assign sel_idx = IDX_W'(pos_ext - CMP_W'(1));
    assign wr_data = DATA_WIDTH'(val_in);

    always_comb begin
        op_ok      = 1'b0;
        is_get     = 1'b0;
        ctl        = '0;
        count_next = count_reg;
        case (func_in)
            FUNC_INSERT: begin
                if ((pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1))
                        && (cnt_ext < CMP_W'(DEPTH))) begin
                    op_ok        = 1'b1;
                    ctl.shift_up = 1'b1;
                    ctl.write    = 1'b1;
                    count_next   = count_reg + CW'(1);
                end
            end
            FUNC_REMOVE: begin
                if ((pos_ext != '0) && (pos_ext <= cnt_ext)) begin
                    op_ok          = 1'b1;
                    ctl.shift_down = 1'b1;
                    count_next     = count_reg - CW'(1);
                end
            end
            FUNC_GET: begin
                if ((pos_ext != '0) && (pos_ext <= cnt_ext)) begin
                    op_ok  = 1'b1;
                    is_get = 1'b1;
                end
            end
            FUNC_SET: begin
                if ((pos_ext != '0) && (pos_ext <= cnt_ext)) begin
                    op_ok     = 1'b1;
                    ctl.write = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                op_ok      = 1'b1;
                count_next = '0;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
        if (!accept) begin
            ctl        = '0;
            count_next = count_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_data;
            logic [DATA_WIDTH-1:0] right_data;

            if (k == 0) begin : g_first
                assign left_data = '0;
            end else begin : g_mid_l
                assign left_data = cell_data[k-1];
            end

            if (k == DEPTH - 1) begin : g_last
                assign right_data = cell_data[k];
            end else begin : g_mid_r
                assign right_data = cell_data[k+1];
            end

            ple_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX_W      (IDX_W)
            ) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .cell_idx   (IDX_W'(k)),
                .sel_idx    (sel_idx),
                .wr_data    (wr_data),
                .left_data  (left_data),
                .right_data (right_data),
                .data       (cell_data[k]),
                .hit        (cell_hit[k])
            );
        end
    endgenerate

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_hit[i]) begin
                rd_data = rd_data | cell_data[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ok_reg         <= op_ok;
            read_value_reg <= is_get ? VALUE_W'(rd_data) : '0;
            length_reg     <= LENGTH_W'(count_next);
            is_empty_reg   <= (count_next == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, is_empty_reg, length_reg, read_value_reg, ok_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ctl.shift_up |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !op_ok |=> $stable(count_reg))
        else $error("rejected item changed the list length");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (is_empty_reg == (length_reg == '0)))
        else $error("empty flag disagrees with length");

    a_one_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctl.shift_up, ctl.shift_down}))
        else $error("cells told to shift both ways");

endmodule

// ----- hdl/ple_cell.sv -----
module ple_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 6
) (
    input  logic                  aclk,
    input  ple_pkg::cell_ctl_t    ctl,
    input  logic [IDX_W-1:0]      cell_idx,
    input  logic [IDX_W-1:0]      sel_idx,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  hit
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    assign hit  = (cell_idx == sel_idx);
    assign data = data_reg;

    always_comb begin
        data_next = data_reg;
        if (ctl.shift_down && (cell_idx >= sel_idx)) begin
            data_next = right_data;
        end else if (ctl.write && hit) begin
            data_next = wr_data;
        end else if (ctl.shift_up && (cell_idx > sel_idx)) begin
            data_next = left_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule
